FILE: hdl/cst_pkg.sv
package cst_pkg;

  // default configuration
  localparam int NUM_SEMS_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 16;

  // fixed field widths
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 5;
  localparam int AMOUNT_W = 16;
  localparam int STATUS_W = 2;
  localparam int VALOUT_W = 16;

  // request codes
  localparam logic [OPCODE_W-1:0] OP_INIT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WAIT   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SIGNAL = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ERR   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCK = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                in_range;
    logic [AMOUNT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                wake;
    logic [VALOUT_W-1:0] value_after;
  } res_t;

  typedef struct packed {
    logic en;
    logic set_active;
  } wr_t;

endpackage

FILE: hdl/cst_mem.sv
module cst_mem #(
  parameter int DEPTH = cst_pkg::NUM_SEMS_DEF,
  parameter int WIDTH = cst_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first: a same-edge write is not seen by the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/cst_update.sv
module cst_update #(
  parameter int VALUE_WIDTH = cst_pkg::VALUE_WIDTH_DEF
) (
  input  cst_pkg::req_t          req,
  input  logic                   active,
  input  logic [VALUE_WIDTH-1:0] cur,
  output cst_pkg::res_t          res,
  output cst_pkg::wr_t           wr,
  output logic [VALUE_WIDTH-1:0] wr_data
);

  // working width covers the value, the amount and one carry bit
  localparam int SW = ((VALUE_WIDTH > cst_pkg::AMOUNT_W) ? VALUE_WIDTH
                                                         : cst_pkg::AMOUNT_W) + 1;

  logic [SW-1:0] cur_w;
  logic [SW-1:0] amt_w;
  logic [SW-1:0] vmax_w;
  logic [SW-1:0] sum_w;
  logic [SW-1:0] val_w;

  assign cur_w  = active ? SW'(cur) : '0;
  assign amt_w  = SW'(req.amount);
  assign vmax_w = SW'({VALUE_WIDTH{1'b1}});
  assign sum_w  = cur_w + amt_w;

  always_comb begin
    res.status = cst_pkg::ST_ERR;
    res.wake   = 1'b0;
    val_w      = cur_w;
    wr.en      = 1'b0;
    wr.set_active = 1'b0;
    if (!req.in_range) begin
      val_w = '0;
    end else begin
      case (req.op)
        cst_pkg::OP_INIT: begin
          if (!active) begin
            res.status    = cst_pkg::ST_OK;
            val_w         = (amt_w > vmax_w) ? vmax_w : amt_w;
            wr.en         = 1'b1;
            wr.set_active = 1'b1;
          end
        end
        cst_pkg::OP_WAIT: begin
          if (active) begin
            if (cur_w < amt_w) begin
              res.status = cst_pkg::ST_BLOCK;
            end else begin
              res.status = cst_pkg::ST_OK;
              val_w      = cur_w - amt_w;
              wr.en      = 1'b1;
            end
          end
        end
        cst_pkg::OP_SIGNAL: begin
          if (active) begin
            if (sum_w > vmax_w) begin
              res.status = cst_pkg::ST_SAT;
              val_w      = vmax_w;
            end else begin
              res.status = cst_pkg::ST_OK;
              val_w      = sum_w;
            end
            res.wake = (val_w != '0);
            wr.en    = 1'b1;
          end
        end
        default: begin
          // unused opcode: error, value reported as is
        end
      endcase
    end
    res.value_after = val_w[cst_pkg::VALOUT_W-1:0];
  end

  assign wr_data = val_w[VALUE_WIDTH-1:0];

endmodule

FILE: hdl/counting_semaphore_table.sv
// bank of counting semaphores, each an unsigned value plus an active flag.
// input channel (in_valid / in_ready): one request per transfer, carrying
// in_opcode (init, wait, signal), in_sem_index and in_amount.
// result channel (out_valid / out_ready): exactly one result per request,
// out_status, out_wake and out_value_after, in request order.
// a wait that cannot be met reports would-block and changes nothing; the
// requester retries. a signal saturates at the largest value.
// a request is taken into the read stage as the ram reads its entry; the
// update then writes its result into the output register once it is free.
// throughput: one request per cycle while the receiver takes results; a
// request hitting the entry written by the one before it takes the new
// value over a bypass register.
// the values sit in a single-port-read, single-port-write synchronous ram;
// the active flags are flip-flops.
// reset: all flags clear at once, so every entry reads as inactive with
// value zero; the ram itself needs no clearing pass. requests are taken
// from the first cycle after reset.
// receiver stall: the result stays in the output register, the request
// behind it waits in the read stage and in_ready drops until it moves on.
module counting_semaphore_table #(
  parameter int NUM_SEMS    = cst_pkg::NUM_SEMS_DEF,
  parameter int VALUE_WIDTH = cst_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cst_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [cst_pkg::INDEX_W-1:0]   in_sem_index,
  input  logic [cst_pkg::AMOUNT_W-1:0]  in_amount,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cst_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_wake,
  output logic [cst_pkg::VALOUT_W-1:0]  out_value_after
);

  localparam int AW = $clog2(NUM_SEMS);

  // handshake
  logic in_fire;
  logic b_fire;

  // read stage: request waiting for its ram data
  logic                         s1_valid_r;
  logic [cst_pkg::OPCODE_W-1:0] s1_op_r;
  logic [AW-1:0]                s1_addr_r;
  logic                         s1_in_range_r;
  logic [cst_pkg::AMOUNT_W-1:0] s1_amt_r;

  // bypass of a write landing on the edge of the read
  logic                   fwd_hit_r;
  logic [VALUE_WIDTH-1:0] fwd_data_r;

  // active flags, one per entry
  logic [NUM_SEMS-1:0] act_r;

  // output register
  logic                         out_valid_r;
  logic [cst_pkg::STATUS_W-1:0] out_status_r;
  logic                         out_wake_r;
  logic [cst_pkg::VALOUT_W-1:0] out_value_r;

  logic [AW-1:0]          in_addr;
  logic                   in_range;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [VALUE_WIDTH-1:0] cur;
  logic                   cur_active;
  cst_pkg::req_t          req;
  cst_pkg::res_t          res;
  cst_pkg::wr_t           wr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   mem_wr_en;

  // the update stage moves on once the output register is free
  assign b_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || b_fire;
  assign in_fire  = in_valid && in_ready;

  assign in_addr  = AW'(in_sem_index);
  assign in_range = (32'(in_sem_index) < 32'(NUM_SEMS));

  assign mem_wr_en = b_fire && wr.en;

  cst_mem #(
    .DEPTH (NUM_SEMS),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data)
  );

  // newest value of the entry: bypass wins over the stale ram read
  assign cur        = fwd_hit_r ? fwd_data_r : rd_data;
  assign cur_active = s1_in_range_r && act_r[s1_addr_r];

  assign req.op       = s1_op_r;
  assign req.in_range = s1_in_range_r;
  assign req.amount   = s1_amt_r;

  cst_update #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_update (
    .req     (req),
    .active  (cur_active),
    .cur     (cur),
    .res     (res),
    .wr      (wr),
    .wr_data (wr_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      act_r       <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (b_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (b_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (b_fire && wr.set_active) begin
        act_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r       <= in_opcode;
      s1_addr_r     <= in_addr;
      s1_in_range_r <= in_range;
      s1_amt_r      <= in_amount;
      fwd_hit_r     <= mem_wr_en && (s1_addr_r == in_addr);
      fwd_data_r    <= wr_data;
    end
    if (b_fire) begin
      out_status_r <= res.status;
      out_wake_r   <= res.wake;
      out_value_r  <= res.value_after;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_wake        = out_wake_r;
  assign out_value_after = out_value_r;

  // a saturated signal always wakes waiters
  a_sat_wakes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == cst_pkg::ST_SAT)) |-> out_wake_r)
    else $error("saturated signal without wake");

  // wake only comes with a successful or saturated result
  a_wake_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_wake_r) |->
      ((out_status_r == cst_pkg::ST_OK) || (out_status_r == cst_pkg::ST_SAT)))
    else $error("wake on a failed request");

  // a stalled request stays in the read stage
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !b_fire) |=> (s1_valid_r && $stable(s1_addr_r)))
    else $error("read stage lost a request");

  // a successful init leaves the entry active
  a_init_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (b_fire && wr.set_active) |=> act_r[$past(s1_addr_r)])
    else $error("init did not set the active flag");

endmodule
